### rtl/arrt_pkg.sv
`timescale 1ns / 1ps

package arrt_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_SIZE_DEF   = 4096;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_FIND     = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_OVERLAP   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] address;
        logic [31:0] num_pages;
        logic [63:0] region_flags;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [63:0] found_start;
        logic [63:0] found_end;
        logic [63:0] found_flags;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic scan_init;
        logic scan_run;
        logic emit;
    } cmd_t;

    typedef struct packed {
        action_t req_action;
        action_t cur_action;
        logic    bad_range;
        logic    scan_done;
        logic    out_busy;
    } stat_t;

endpackage

### rtl/arrt_ctrl.sv
`timescale 1ns / 1ps

module arrt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  arrt_pkg::stat_t stat,
    output arrt_pkg::cmd_t  cmd
);

    arrt_pkg::state_t state_reg;
    arrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            arrt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.scan_init = 1'b1;
                    unique case (stat.req_action)
                        arrt_pkg::ACT_REGISTER: state_next = arrt_pkg::S_MUL;
                        arrt_pkg::ACT_FIND:     state_next = arrt_pkg::S_SCAN;
                        default:                state_next = arrt_pkg::S_DONE;
                    endcase
                end
            end
            arrt_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = arrt_pkg::S_ADD;
            end
            arrt_pkg::S_ADD:
            begin
                cmd.add       = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = arrt_pkg::S_SCAN;
            end
            arrt_pkg::S_SCAN:
            begin
                if (stat.cur_action == arrt_pkg::ACT_REGISTER && stat.bad_range)
                begin
                    state_next = arrt_pkg::S_DONE;
                end
                else if (stat.scan_done)
                begin
                    state_next = arrt_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            arrt_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = arrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = arrt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/arrt_dp.sv
`timescale 1ns / 1ps

module arrt_dp #(
    parameter int MAX_REGIONS = arrt_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SIZE   = arrt_pkg::PAGE_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  arrt_pkg::in_item_t  in_data,
    input  arrt_pkg::cmd_t      cmd,
    output arrt_pkg::stat_t     stat,
    output logic                out_valid,
    input  logic                out_ready,
    output arrt_pkg::out_item_t out_data
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int PW = $clog2(PAGE_SIZE + 1);
    localparam int MW = 32 + PW;
    localparam logic [IW:0] NUM_SLOTS = (IW + 1)'(MAX_REGIONS);

    arrt_pkg::in_item_t  cur_reg;
    logic [MW-1:0]       prod_reg;
    logic [63:0]         limit_reg;
    logic                carry_reg;
    logic                zero_cnt;

    logic [63:0]         start_mem [MAX_REGIONS];
    logic [63:0]         end_mem   [MAX_REGIONS];
    logic [63:0]         flags_mem [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] valid_reg;

    logic [IW:0]         issue_cnt_reg;
    logic [IW-1:0]       rd_idx;
    logic                issuing;
    logic                chk_live_reg;
    logic                chk_valid_reg;
    logic [IW-1:0]       chk_idx_reg;
    logic [63:0]         rd_start_reg;
    logic [63:0]         rd_end_reg;
    logic [63:0]         rd_flags_reg;

    logic                hit_reg;
    logic [63:0]         hit_start_reg;
    logic [63:0]         hit_end_reg;
    logic [63:0]         hit_flags_reg;
    logic                free_ok_reg;
    logic [IW-1:0]       free_idx_reg;

    logic                match;
    logic [64:0]         sum;
    arrt_pkg::status_t   reg_status;
    logic                commit;

    arrt_pkg::out_item_t out_reg;
    arrt_pkg::out_item_t out_next;
    logic                out_valid_reg;

    assign zero_cnt = (cur_reg.num_pages == 32'd0);
    assign sum      = {1'b0, cur_reg.address} + 65'(prod_reg);
    assign rd_idx   = issue_cnt_reg[IW-1:0];
    assign issuing  = cmd.scan_run && (issue_cnt_reg < NUM_SLOTS) && !hit_reg;

    always_comb
    begin
        match = 1'b0;
        if (chk_live_reg && chk_valid_reg && !hit_reg)
        begin
            if (cur_reg.action == arrt_pkg::ACT_FIND)
            begin
                match = (cur_reg.address >= rd_start_reg) && (cur_reg.address < rd_end_reg);
            end
            else
            begin
                match = (cur_reg.address < rd_end_reg) && (rd_start_reg < limit_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= in_data;
        end
        if (cmd.mul)
        begin
            prod_reg <= MW'(cur_reg.num_pages) * MW'(PAGE_SIZE);
        end
        if (cmd.add)
        begin
            limit_reg <= sum[63:0];
            carry_reg <= sum[64];
        end
        if (issuing)
        begin
            rd_start_reg  <= start_mem[rd_idx];
            rd_end_reg    <= end_mem[rd_idx];
            rd_flags_reg  <= flags_mem[rd_idx];
            chk_valid_reg <= valid_reg[rd_idx];
            chk_idx_reg   <= rd_idx;
        end
        if (match)
        begin
            hit_start_reg <= rd_start_reg;
            hit_end_reg   <= rd_end_reg;
            hit_flags_reg <= rd_flags_reg;
        end
        if (chk_live_reg && !chk_valid_reg && !free_ok_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (commit)
        begin
            start_mem[free_idx_reg] <= cur_reg.address;
            end_mem[free_idx_reg]   <= limit_reg;
            flags_mem[free_idx_reg] <= cur_reg.region_flags;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            chk_live_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            free_ok_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                issue_cnt_reg <= '0;
                chk_live_reg  <= 1'b0;
                hit_reg       <= 1'b0;
                free_ok_reg   <= 1'b0;
            end
            else
            begin
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                chk_live_reg <= issuing;
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (chk_live_reg && !chk_valid_reg)
                begin
                    free_ok_reg <= 1'b1;
                end
            end
            if (commit)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (cmd.emit && cur_reg.action == arrt_pkg::ACT_CLEAR)
            begin
                valid_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (zero_cnt || carry_reg)
        begin
            reg_status = arrt_pkg::ST_BAD_RANGE;
        end
        else if (hit_reg)
        begin
            reg_status = arrt_pkg::ST_OVERLAP;
        end
        else if (!free_ok_reg)
        begin
            reg_status = arrt_pkg::ST_FULL;
        end
        else
        begin
            reg_status = arrt_pkg::ST_OK;
        end
    end

    assign commit = cmd.emit && (cur_reg.action == arrt_pkg::ACT_REGISTER) &&
                    (reg_status == arrt_pkg::ST_OK);

    always_comb
    begin
        out_next        = '0;
        out_next.status = arrt_pkg::ST_OK;
        unique case (cur_reg.action)
            arrt_pkg::ACT_REGISTER:
            begin
                out_next.status = reg_status;
            end
            arrt_pkg::ACT_FIND:
            begin
                if (hit_reg)
                begin
                    out_next.found       = 1'b1;
                    out_next.found_start = hit_start_reg;
                    out_next.found_end   = hit_end_reg;
                    out_next.found_flags = hit_flags_reg;
                end
            end
            default:
            begin
                out_next.found = 1'b0;
            end
        endcase
    end

    assign stat.req_action = in_data.action;
    assign stat.cur_action = cur_reg.action;
    assign stat.bad_range  = zero_cnt || carry_reg;
    assign stat.scan_done  = hit_reg || ((issue_cnt_reg == NUM_SLOTS) && !chk_live_reg);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_emit_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !out_ready))
        else $error("Result written over an item not yet taken.");

    a_commit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !valid_reg[free_idx_reg])
        else $error("Region stored into an occupied slot.");

    a_valid_only_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cur_reg.action == arrt_pkg::ACT_CLEAR)
        |=> $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("Slot lost its valid bit outside a clear.");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= NUM_SLOTS)
        else $error("Scan counter ran past the table.");

    a_found_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && out_next.found |-> out_next.status == arrt_pkg::ST_OK)
        else $error("Find result carries a non-zero status.");

endmodule

### rtl/anon_region_range_table.sv
`timescale 1ns / 1ps

// Region table holding up to MAX_REGIONS half-open address ranges with flags.
// Each input item carries an action: register a range of num_pages pages of
// PAGE_SIZE bytes at address, find the region containing address, or clear
// the table. Every item yields exactly one result item with a status code.
// Both channels use valid/ready; in_ready is high only while the block is
// idle, and a finished result sits in an output register so that the next
// item may be accepted while the receiver stalls. A stalled receiver only
// delays the point at which the following result can be written.
// A register multiplies num_pages by PAGE_SIZE, adds the address to form the
// limit and then scans the slots; a find scans the slots directly; a clear or
// an unused action goes straight to the result. The slot scan reads one table
// entry per cycle from the single memory read port and stops early at the
// first overlap or match. One item is in work at a time, and in_ready returns
// once the result is written.
// Reset clears all valid bits, so the table starts empty.

module anon_region_range_table #(
    parameter int MAX_REGIONS = arrt_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SIZE   = arrt_pkg::PAGE_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  arrt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output arrt_pkg::out_item_t out_data
);

    arrt_pkg::cmd_t  cmd;
    arrt_pkg::stat_t stat;

    arrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    arrt_dp #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SIZE   (PAGE_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

class region_ledger;
    localparam int SLOTS = arrt_pkg::MAX_REGIONS_DEF;
    localparam int PAGE_BYTES = arrt_pkg::PAGE_SIZE_DEF;

    bit                  live [SLOTS];
    logic [63:0]         lo [SLOTS];
    logic [63:0]         hi [SLOTS];
    logic [63:0]         tag [SLOTS];
    arrt_pkg::out_item_t pending_q [$];
    int                  mismatches;

    function new();
        foreach (live[i])
        begin
            live[i] = 1'b0;
            lo[i] = '0;
            hi[i] = '0;
            tag[i] = '0;
        end
        mismatches = 0;
    endfunction

    function arrt_pkg::status_t try_register(logic [63:0] base, logic [31:0] pages,
                                             logic [63:0] flags);
        logic [63:0] limit;
        int          free_idx;
        free_idx = -1;
        if (pages == 32'd0)
            return arrt_pkg::ST_BAD_RANGE;
        limit = base + 64'(pages) * 64'(PAGE_BYTES);
        if (limit <= base)
            return arrt_pkg::ST_BAD_RANGE;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (live[i])
            begin
                if (base < hi[i] && lo[i] < limit)
                    return arrt_pkg::ST_OVERLAP;
            end
            else if (free_idx < 0)
            begin
                free_idx = i;
            end
        end
        if (free_idx < 0)
            return arrt_pkg::ST_FULL;
        live[free_idx] = 1'b1;
        lo[free_idx] = base;
        hi[free_idx] = limit;
        tag[free_idx] = flags;
        return arrt_pkg::ST_OK;
    endfunction

    function void note_request(arrt_pkg::in_item_t req);
        arrt_pkg::out_item_t rsp;
        rsp = '0;
        case (req.action)
            arrt_pkg::ACT_REGISTER:
            begin
                rsp.status = try_register(req.address, req.num_pages, req.region_flags);
            end
            arrt_pkg::ACT_FIND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!rsp.found && live[i] && req.address >= lo[i]
                        && req.address < hi[i])
                    begin
                        rsp.found = 1'b1;
                        rsp.found_start = lo[i];
                        rsp.found_end = hi[i];
                        rsp.found_flags = tag[i];
                    end
                end
            end
            arrt_pkg::ACT_CLEAR:
            begin
                foreach (live[i])
                    live[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        pending_q.push_back(rsp);
    endfunction

    function void check_response(arrt_pkg::out_item_t got);
        arrt_pkg::out_item_t want;
        if (pending_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: result item with nothing outstanding", $realtime);
            mismatches++;
            return;
        end
        want = pending_q.pop_front();
        if (got.status !== want.status || got.found !== want.found
            || got.found_start !== want.found_start || got.found_end !== want.found_end
            || got.found_flags !== want.found_flags)
        begin
            if (mismatches < 10)
            begin
                $display("%0t: mismatch status %0d/%0d found %0d/%0d (exp/act)",
                         $realtime, want.status, got.status, want.found, got.found);
                $display("    start %h/%h end %h/%h flags %h/%h",
                         want.found_start, got.found_start, want.found_end,
                         got.found_end, want.found_flags, got.found_flags);
            end
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 174;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    arrt_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    arrt_pkg::out_item_t out_data;

    int send_idle_pct = 30;
    int recv_idle_pct = 88;
    int quiet_cycles = 0;

    region_ledger ledger = new();

    anon_region_range_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ledger.note_request(in_data);
            if (out_valid && out_ready)
                ledger.check_response(out_data);
        end
    end

    function automatic arrt_pkg::in_item_t make_request(arrt_pkg::action_t act,
                                                        logic [63:0] addr,
                                                        logic [31:0] pages,
                                                        logic [63:0] flags);
        arrt_pkg::in_item_t it;
        it.action = act;
        it.address = addr;
        it.num_pages = pages;
        it.region_flags = flags;
        return it;
    endfunction

    function automatic arrt_pkg::in_item_t random_request();
        arrt_pkg::in_item_t it;
        int                 picks [$];
        int                 k;
        int                 roll;
        logic [63:0]        span;
        it = make_request(arrt_pkg::ACT_NONE, {$urandom, $urandom}, $urandom,
                          {$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 48)
        begin
            it.action = arrt_pkg::ACT_REGISTER;
            k = $urandom_range(0, 99);
            if (k < 70)
            begin
                it.address = 64'($urandom_range(0, 255)) << 12;
                if ($urandom_range(0, 3) == 0)
                    it.address[11:0] = 12'($urandom);
                it.num_pages = $urandom_range(1, 8);
            end
            else if (k < 80)
            begin
                it.address = 64'hFFFF_FFFF_FFFF_F000 - (64'($urandom_range(0, 20)) << 12);
                it.num_pages = $urandom_range(1, 24);
            end
            else if (k < 88)
            begin
                it.num_pages = '0;
            end
        end
        else if (roll < 92)
        begin
            it.action = arrt_pkg::ACT_FIND;
            foreach (ledger.live[i])
                if (ledger.live[i])
                    picks.push_back(i);
            if (picks.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                k = picks[$urandom_range(0, picks.size() - 1)];
                span = ledger.hi[k] - ledger.lo[k];
                case ($urandom_range(0, 4))
                    0: it.address = ledger.lo[k];
                    1: it.address = ledger.hi[k] - 64'd1;
                    2: it.address = ledger.hi[k];
                    3: it.address = ledger.lo[k] - 64'd1;
                    default: it.address = ledger.lo[k] + ({$urandom, $urandom} % span);
                endcase
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                it.address = 64'($urandom_range(0, 1 << 20));
            end
        end
        else if (roll < 98)
        begin
            it.action = arrt_pkg::ACT_CLEAR;
        end
        return it;
    endfunction

    task automatic send_item(arrt_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (ledger.pending_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'd0, 32'd1, '1));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'h10_0000, 32'd0, 64'd5));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'hFFFF_FFFF_FFFF_F000, 32'd1,
                               64'd6));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'hFFFF_FFFF_FFFF_E000, 32'd1,
                               64'd0));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'hFFFF_FFFF_0000_0000, '1, '1));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'h800, 32'd1, 64'd7));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'h1000, 32'd1,
                               64'h1234_5678_9ABC_DEF0));
        send_item(make_request(arrt_pkg::ACT_FIND, 64'hFFF, '1, '1));
        send_item(make_request(arrt_pkg::ACT_FIND, 64'h1000, '0, '0));
        send_item(make_request(arrt_pkg::ACT_FIND, 64'hFFFF_FFFF_FFFF_EFFF, '0, '0));
        send_item(make_request(arrt_pkg::ACT_FIND, 64'h2000, '0, '0));
        send_item(make_request(arrt_pkg::ACT_NONE, '1, '1, '1));
        for (int i = 0; i < 13; i++)
            send_item(make_request(arrt_pkg::ACT_REGISTER, 64'(i + 4) << 16, 32'd2,
                                   {$urandom, $urandom}));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'h1_0000_0000, 32'd1, 64'd9));
        send_item(make_request(arrt_pkg::ACT_REGISTER, 64'd0, 32'd1, 64'd9));
        send_item(make_request(arrt_pkg::ACT_CLEAR, '0, '0, '0));
        send_item(make_request(arrt_pkg::ACT_FIND, 64'd0, '0, '0));
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_request());
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
